// ----- rtl/aglk_pkg.sv -----
// ----------------------------------------------------------------------------
// aglk_pkg
// Shared constants, types and state codes of the glyph lookup engine.
// ----------------------------------------------------------------------------
package aglk_pkg;

	localparam int TABLE_WORDS = 32768;
	localparam int ADDR_W      = $clog2(TABLE_WORDS);
	localparam int BADDR_W     = 34;
	localparam int VS_W        = 7;
	localparam int VS_RESET    = 2;

	localparam logic [15:0] FMT_SIMPLE  = 16'd0;
	localparam logic [15:0] FMT_SEGSNG  = 16'd2;
	localparam logic [15:0] FMT_SEGARR  = 16'd4;
	localparam logic [15:0] FMT_SINGLE  = 16'd6;
	localparam logic [15:0] FMT_TRIM    = 16'd8;
	localparam logic [15:0] FMT_EXTTRIM = 16'd10;

	localparam logic [BADDR_W-1:0] HDR_W1   = BADDR_W'(2);
	localparam logic [BADDR_W-1:0] HDR_W2   = BADDR_W'(4);
	localparam logic [BADDR_W-1:0] HDR_W3   = BADDR_W'(6);
	localparam logic [15:0]        UNIT_BASE = 16'd12;
	localparam logic [15:0]        F0_BASE   = 16'd2;
	localparam logic [15:0]        F8_BASE   = 16'd6;
	localparam logic [15:0]        F10_BASE  = 16'd8;
	localparam logic [BADDR_W-1:0] STORE_BYTES = BADDR_W'(2 * TABLE_WORDS);

	typedef enum logic [4:0] {
		ST_IDLE, ST_F0, ST_F1, ST_F2, ST_FMT, ST_H1, ST_H2, ST_H3, ST_LOOP,
		ST_AMUL, ST_AADD, ST_P1, ST_P2, ST_BASE, ST_OMUL, ST_OADD, ST_FIN
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       wdata;
	} ram_req_t;

	typedef struct packed {
		logic        found;
		logic [15:0] offset;
	} res_t;

endpackage

// ----- rtl/aglk_ram.sv -----
// ----------------------------------------------------------------------------
// aglk_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module aglk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- rtl/aglk_ctrl.sv -----
// ----------------------------------------------------------------------------
// aglk_ctrl
// Lookup sequencer: table reads, binary search, shared multiplier.
// ----------------------------------------------------------------------------
module aglk_ctrl import aglk_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            req_type,
	input  logic [14:0]     word_addr,
	input  logic [15:0]     word_data,
	input  logic [15:0]     glyph,
	input  logic [VS_W-1:0] value_size,
	output ram_req_t        ram_req,
	input  logic [15:0]     ram_rdata,
	output logic            res_valid,
	output res_t            res,
	input  logic            res_ready
);

	state_t state_q, state_d, ret_q;

	logic [BADDR_W-1:0] baddr_q, a_q, off_q;
	logic [7:0]         fbyte_q;
	logic [15:0]        fw_q, glyph_q, fmt_q, unit_q, first_q, last_q;
	logic [15:0]        lo_q, hi_q, mid_q, mula_q, mulb_q, add_q;
	logic [31:0]        prod_q;
	logic               ok_q;

	logic               accept;
	logic [BADDR_W-2:0] widx0, widx1;
	logic               v0, v1;
	logic [15:0]        mid, idx8, idx10, gdiff;
	logic               g_lt, g_gt, g_gt_last;
	logic               is_seg;
	logic [BADDR_W-1:0] a_new;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign widx0     = baddr_q[BADDR_W-1:1];
	assign widx1     = widx0 + 1'b1;
	assign v0        = widx0 < (BADDR_W-1)'(TABLE_WORDS);
	assign v1        = widx1 < (BADDR_W-1)'(TABLE_WORDS);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign idx8      = glyph_q - unit_q;
	assign idx10     = glyph_q - first_q;
	assign gdiff     = glyph_q - first_q;
	assign g_lt      = glyph_q < fw_q;
	assign g_gt      = glyph_q > fw_q;
	assign g_gt_last = glyph_q > last_q;
	assign is_seg    = (fmt_q == FMT_SEGSNG) || (fmt_q == FMT_SEGARR) ||
		(fmt_q == FMT_SINGLE);
	assign a_new     = BADDR_W'(UNIT_BASE) + BADDR_W'(prod_q);

	always_comb begin
		ram_req.we    = accept && !req_type &&
			({2'b0, word_addr} < 17'(TABLE_WORDS));
		ram_req.wdata = word_data;
		case (state_q)
			ST_IDLE: ram_req.addr = word_addr[ADDR_W-1:0];
			ST_F1:   ram_req.addr = widx1[ADDR_W-1:0];
			default: ram_req.addr = widx0[ADDR_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		res_valid = 1'b0;
		res.found = ok_q && (off_q < STORE_BYTES);
		res.offset = res.found ? off_q[15:0] : 16'h0;
		case (state_q)
			ST_IDLE: begin
				if (accept && req_type) state_d = ST_F0;
			end
			ST_F0: state_d = ST_F1;
			ST_F1: state_d = baddr_q[0] ? ST_F2 : ret_q;
			ST_F2: state_d = ret_q;
			ST_FMT: begin
				case (fw_q)
					FMT_SIMPLE: state_d = ST_OMUL;
					FMT_SEGSNG, FMT_SEGARR, FMT_SINGLE, FMT_TRIM, FMT_EXTTRIM:
						state_d = ST_F0;
					default: state_d = ST_FIN;
				endcase
			end
			ST_H1: state_d = ST_F0;
			ST_H2: begin
				if (is_seg) state_d = ST_LOOP;
				else if (fmt_q == FMT_TRIM) state_d = (idx8 >= fw_q) ? ST_FIN : ST_OMUL;
				else state_d = ST_F0;
			end
			ST_H3: state_d = (idx10 >= fw_q) ? ST_FIN : ST_OMUL;
			ST_LOOP: state_d = (lo_q < hi_q) ? ST_AMUL : ST_FIN;
			ST_AMUL: state_d = ST_AADD;
			ST_AADD: state_d = ST_F0;
			ST_P1: begin
				if (fmt_q == FMT_SINGLE) state_d = (g_lt || g_gt) ? ST_LOOP : ST_FIN;
				else state_d = ST_F0;
			end
			ST_P2: begin
				if (g_lt || g_gt_last) state_d = ST_LOOP;
				else if (fmt_q == FMT_SEGARR) state_d = ST_F0;
				else state_d = ST_FIN;
			end
			ST_BASE: state_d = ST_OMUL;
			ST_OMUL: state_d = ST_OADD;
			ST_OADD: state_d = ST_FIN;
			ST_FIN: begin
				res_valid = 1'b1;
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q  <= 1'b0;
			ret_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && req_type) begin
						glyph_q <= glyph;
						ok_q    <= 1'b0;
						baddr_q <= '0;
						ret_q   <= ST_FMT;
					end
				end
				ST_F1: begin
					if (!baddr_q[0]) fw_q <= v0 ? ram_rdata : 16'h0;
					else fbyte_q <= v0 ? ram_rdata[7:0] : 8'h0;
				end
				ST_F2: fw_q <= {fbyte_q, v1 ? ram_rdata[15:8] : 8'h0};
				ST_FMT: begin
					fmt_q   <= fw_q;
					mula_q  <= glyph_q;
					mulb_q  <= 16'(value_size);
					add_q   <= F0_BASE;
					baddr_q <= HDR_W1;
					ret_q   <= ST_H1;
				end
				ST_H1: begin
					unit_q  <= fw_q;
					baddr_q <= HDR_W2;
					ret_q   <= ST_H2;
				end
				ST_H2: begin
					lo_q    <= '0;
					hi_q    <= fw_q;
					first_q <= fw_q;
					mula_q  <= idx8;
					mulb_q  <= 16'(value_size);
					add_q   <= F8_BASE;
					baddr_q <= HDR_W3;
					ret_q   <= ST_H3;
				end
				ST_H3: begin
					mula_q <= idx10;
					mulb_q <= unit_q;
					add_q  <= F10_BASE;
				end
				ST_LOOP: begin
					mid_q  <= mid;
					mula_q <= mid;
					mulb_q <= unit_q;
				end
				ST_AMUL, ST_OMUL: prod_q <= mula_q * mulb_q;
				ST_AADD: begin
					a_q     <= a_new;
					baddr_q <= a_new;
					ret_q   <= ST_P1;
				end
				ST_P1: begin
					if (fmt_q == FMT_SINGLE) begin
						if (g_lt) hi_q <= mid_q;
						else if (g_gt) lo_q <= mid_q + 16'd1;
						else begin
							ok_q  <= 1'b1;
							off_q <= a_q + BADDR_W'(2);
						end
					end else begin
						last_q  <= fw_q;
						baddr_q <= a_q + BADDR_W'(2);
						ret_q   <= ST_P2;
					end
				end
				ST_P2: begin
					first_q <= fw_q;
					if (g_lt) hi_q <= mid_q;
					else if (g_gt_last) lo_q <= mid_q + 16'd1;
					else if (fmt_q == FMT_SEGARR) begin
						baddr_q <= a_q + BADDR_W'(4);
						ret_q   <= ST_BASE;
					end else begin
						ok_q  <= 1'b1;
						off_q <= a_q + BADDR_W'(4);
					end
				end
				ST_BASE: begin
					mula_q <= gdiff;
					mulb_q <= 16'(value_size);
					add_q  <= fw_q;
				end
				ST_OADD: begin
					ok_q  <= 1'b1;
					off_q <= BADDR_W'(add_q) + BADDR_W'(prod_q);
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/aat_glyph_lookup_engine.sv -----
// ----------------------------------------------------------------------------
// aat_glyph_lookup_engine
// AAT lookup table store and glyph-to-value-offset resolver.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall): req_type 0 writes word_data into
// word word_addr of the table store and gives no result; req_type 1 looks
// up glyph. Result channel (rsp_valid/rsp_stall): found and value_offset.
// Config channel (cfg_valid/cfg_ready): value_size, always ready; write only
// while idle. A write request is written to the store when it is accepted.
// A lookup runs through one sequencer sharing the single store port: a
// 16-bit read issues its word address in ST_F0 and takes the word in
// ST_F1; an unaligned read also fetches the next word and joins the bytes
// in ST_F2. Formats 2, 4 and 6 binary-search their units, up to 16 probes;
// format 4 reads a value base on a hit. Unknown formats are not found.
// One request is in flight at a time; the next is taken the cycle after the
// result moves to the output register. A stalled result holds, and a
// finished lookup waits until the output register is free.
// Reset returns the sequencer to idle, clears rsp_valid and sets
// value_size to 2; the store contents are undefined until written.
// ----------------------------------------------------------------------------
module aat_glyph_lookup_engine import aglk_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            req_type,
	input  logic [14:0]     word_addr,
	input  logic [15:0]     word_data,
	input  logic [15:0]     glyph,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output logic            found,
	output logic [15:0]     value_offset,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [VS_W-1:0] cfg_data
);

	logic [VS_W-1:0] vs_q;
	ram_req_t        ram_req;
	logic [15:0]     ram_rdata;
	logic            res_valid, res_ready;
	res_t            res;
	logic            rsp_valid_q;
	res_t            rsp_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs_q <= VS_W'(VS_RESET);
		end else if (cfg_valid) begin
			vs_q <= cfg_data;
		end
	end

	aglk_ram #(.WIDTH(16), .DEPTH(TABLE_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	aglk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.word_addr  (word_addr),
		.word_data  (word_data),
		.glyph      (glyph),
		.value_size (vs_q),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready)
	);

	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign found        = rsp_q.found;
	assign value_offset = rsp_q.offset;

endmodule

// ----- rtl/aglk_checker.sv -----
// ----------------------------------------------------------------------------
// aglk_checker
// Port-level checks of the glyph lookup engine, bound to the top level.
// ----------------------------------------------------------------------------
module aglk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        req_type,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        found,
	input logic [15:0] value_offset
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(found) && $stable(value_offset))
		else $error("stalled result changed");

	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> value_offset == 16'h0)
		else $error("not-found result with nonzero offset");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !req_type && !rsp_valid |=> !rsp_valid)
		else $error("write request produced a result");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type |=> req_stall)
		else $error("lookup request did not occupy the engine");

endmodule

bind aat_glyph_lookup_engine aglk_checker u_aglk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.req_type     (req_type),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.found        (found),
	.value_offset (value_offset)
);
